// ===== rtl/bldc6s_pkg.sv =====
// Shared types, register codes, reset values and commutation tables for the
// hall-sensor six-step commutator. No dependencies.
package bldc6s_pkg;

    localparam int DUTY_W     = 14;
    localparam int INTERVAL_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef logic [DUTY_W-1:0]     duty_t;
    typedef logic [INTERVAL_W-1:0] interval_t;
    typedef logic [1:0]            phase_t;

    localparam duty_t DUTY_CEIL = duty_t'(10000);

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 3'd4;

    localparam logic      RST_DIRECTION     = 1'b1;
    localparam duty_t     RST_DUTY_MIN      = duty_t'(500);
    localparam duty_t     RST_DUTY_MAX      = duty_t'(7000);
    localparam duty_t     RST_DUTY_STEP     = duty_t'(500);
    localparam interval_t RST_RAMP_INTERVAL = interval_t'(50000);
    localparam duty_t     RST_RAMP_DUTY     = duty_t'(500);

    localparam logic [2:0] HALL_NONE_LO = 3'd0;
    localparam logic [2:0] HALL_NONE_HI = 3'd7;

    localparam phase_t PHASE_U = 2'd0;
    localparam phase_t PHASE_V = 2'd1;
    localparam phase_t PHASE_W = 2'd2;

    function automatic duty_t sat_duty(input duty_t v);
        return (v > DUTY_CEIL) ? DUTY_CEIL : v;
    endfunction

    // high side per commutation step: u v v w u w
    function automatic phase_t step_high(input logic [2:0] idx);
        phase_t p;
        unique case (idx)
            3'd0:    p = PHASE_U;
            3'd1:    p = PHASE_V;
            3'd2:    p = PHASE_V;
            3'd3:    p = PHASE_W;
            3'd4:    p = PHASE_U;
            default: p = PHASE_W;
        endcase
        return p;
    endfunction

    // low side per commutation step: w u w v v u
    function automatic phase_t step_low(input logic [2:0] idx);
        phase_t p;
        unique case (idx)
            3'd0:    p = PHASE_W;
            3'd1:    p = PHASE_U;
            3'd2:    p = PHASE_W;
            3'd3:    p = PHASE_V;
            3'd4:    p = PHASE_V;
            default: p = PHASE_U;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/bldc_hall_six_step_commutator_top.sv =====
// Hall-sensor six-step BLDC commutator with a triangle duty ramp.
// Depends on bldc6s_pkg for types, register codes, reset values and step tables.
//
// Usage:
//   s_* channel: one word per PWM period, s_tdata[2:0] = hall code (u, v, w).
//   m_* channel: one word per input word, three high-side duties, three
//   low-side enables, and m_tuser = hall fault for codes 0 and 7.
//   cfg_* channel: register writes, always ready; write only while idle.
//     index 0 direction, 1 duty_min, 2 duty_max, 3 duty_step, 4 ramp_interval;
//     other indexes are dropped.
// m_tvalid rises in the cycle after input acceptance; throughput is one word
// per cycle while the receiver does not stall. Tick counter and ramp update in
// the same cycle the word is accepted, and the result lands in the single output register.
// When the receiver stalls, the output register holds its word and s_tready
// drops until that word is taken; s_tready stays high while the output
// register is empty or being drained in the same cycle.
// Reset clears the output valid, the tick counter, sets the ramp to 500 and
// rising, and loads the register defaults.
module bldc_hall_six_step_commutator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] hall_code, [7:3] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [13:0] duty_u, [27:14] duty_v, [41:28] duty_w,
                                   // [42] low_u_on, [43] low_v_on, [44] low_w_on,
                                   // [47:45] zero
    output logic [0:0]  m_tuser,   // [0] hall_fault
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bldc6s_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bldc6s_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                  direction_reg;
    bldc6s_pkg::duty_t     duty_min_reg;
    bldc6s_pkg::duty_t     duty_max_reg;
    bldc6s_pkg::duty_t     duty_step_reg;
    bldc6s_pkg::interval_t ramp_interval_reg;

    bldc6s_pkg::interval_t tick_count_reg, tick_count_next;
    bldc6s_pkg::duty_t     ramp_duty_reg, ramp_duty_next;
    logic                  ramp_rising_reg, ramp_rising_next;

    logic                  out_valid_reg;
    bldc6s_pkg::duty_t     duty_u_reg, duty_u_next;
    bldc6s_pkg::duty_t     duty_v_reg, duty_v_next;
    bldc6s_pkg::duty_t     duty_w_reg, duty_w_next;
    logic [2:0]            low_on_reg, low_on_next;
    logic                  fault_reg, fault_next;

    logic                  in_fire;
    logic [2:0]            hall;
    logic [bldc6s_pkg::INTERVAL_W:0] tick_inc;
    logic                  ramp_hit;
    bldc6s_pkg::duty_t     lo, hi, st;
    logic [bldc6s_pkg::DUTY_W:0] rise_sum, fall_diff;
    logic [2:0]            step_idx;
    bldc6s_pkg::phase_t    hi_phase, lo_phase;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign hall      = s_tdata[2:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg     <= bldc6s_pkg::RST_DIRECTION;
            duty_min_reg      <= bldc6s_pkg::RST_DUTY_MIN;
            duty_max_reg      <= bldc6s_pkg::RST_DUTY_MAX;
            duty_step_reg     <= bldc6s_pkg::RST_DUTY_STEP;
            ramp_interval_reg <= bldc6s_pkg::RST_RAMP_INTERVAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bldc6s_pkg::REG_DIRECTION:     direction_reg <= cfg_data[0];
                bldc6s_pkg::REG_DUTY_MIN:
                    duty_min_reg <= cfg_data[bldc6s_pkg::DUTY_W-1:0];
                bldc6s_pkg::REG_DUTY_MAX:
                    duty_max_reg <= cfg_data[bldc6s_pkg::DUTY_W-1:0];
                bldc6s_pkg::REG_DUTY_STEP:
                    duty_step_reg <= cfg_data[bldc6s_pkg::DUTY_W-1:0];
                bldc6s_pkg::REG_RAMP_INTERVAL: ramp_interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // tick counter and ramp
    always_comb
    begin
        lo        = bldc6s_pkg::sat_duty(duty_min_reg);
        hi        = bldc6s_pkg::sat_duty(duty_max_reg);
        st        = bldc6s_pkg::sat_duty(duty_step_reg);
        tick_inc  = {1'b0, tick_count_reg} + 1'b1;
        ramp_hit  = tick_inc >= {1'b0, ramp_interval_reg};
        rise_sum  = {1'b0, ramp_duty_reg} + {1'b0, st};
        fall_diff = {1'b0, ramp_duty_reg} - {1'b0, st};

        tick_count_next  = tick_inc[bldc6s_pkg::INTERVAL_W-1:0];
        ramp_duty_next   = ramp_duty_reg;
        ramp_rising_next = ramp_rising_reg;
        if (ramp_hit)
        begin
            tick_count_next = '0;
            if (ramp_rising_reg)
            begin
                if (rise_sum >= {1'b0, hi})
                begin
                    ramp_duty_next   = hi;
                    ramp_rising_next = 1'b0;
                end
                else
                begin
                    ramp_duty_next = rise_sum[bldc6s_pkg::DUTY_W-1:0];
                end
            end
            else
            begin
                if (fall_diff[bldc6s_pkg::DUTY_W] ||
                    fall_diff[bldc6s_pkg::DUTY_W-1:0] <= lo)
                begin
                    ramp_duty_next   = lo;
                    ramp_rising_next = 1'b1;
                end
                else
                begin
                    ramp_duty_next = fall_diff[bldc6s_pkg::DUTY_W-1:0];
                end
            end
        end
    end

    // commutation
    always_comb
    begin
        step_idx    = direction_reg ? (3'd6 - hall) : (hall - 3'd1);
        hi_phase    = bldc6s_pkg::step_high(step_idx);
        lo_phase    = bldc6s_pkg::step_low(step_idx);
        fault_next  = (hall == bldc6s_pkg::HALL_NONE_LO) ||
                      (hall == bldc6s_pkg::HALL_NONE_HI);
        duty_u_next = '0;
        duty_v_next = '0;
        duty_w_next = '0;
        low_on_next = '0;
        if (!fault_next)
        begin
            unique case (hi_phase)
                bldc6s_pkg::PHASE_U: duty_u_next = ramp_duty_next;
                bldc6s_pkg::PHASE_V: duty_v_next = ramp_duty_next;
                default:             duty_w_next = ramp_duty_next;
            endcase
            unique case (lo_phase)
                bldc6s_pkg::PHASE_U: low_on_next = 3'b001;
                bldc6s_pkg::PHASE_V: low_on_next = 3'b010;
                default:             low_on_next = 3'b100;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            ramp_duty_reg   <= bldc6s_pkg::RST_RAMP_DUTY;
            ramp_rising_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                tick_count_reg  <= tick_count_next;
                ramp_duty_reg   <= ramp_duty_next;
                ramp_rising_reg <= ramp_rising_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            duty_u_reg <= duty_u_next;
            duty_v_reg <= duty_v_next;
            duty_w_reg <= duty_w_next;
            low_on_reg <= low_on_next;
            fault_reg  <= fault_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, low_on_reg, duty_w_reg, duty_v_reg, duty_u_reg};
    assign m_tuser  = fault_reg;

    a_fault_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fault_reg) |->
        (low_on_reg == 3'b000 && duty_u_reg == '0 && duty_v_reg == '0 &&
         duty_w_reg == '0))
        else $error("fault word drives a switch");

    a_one_low_side: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fault_reg) |-> $onehot(low_on_reg))
        else $error("low-side enable not one-hot");

    a_one_high_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        ($countones({duty_u_reg != '0, duty_v_reg != '0, duty_w_reg != '0}) <= 1))
        else $error("more than one high side driven");

    a_duty_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_duty_reg <= bldc6s_pkg::DUTY_CEIL)
        else $error("ramp duty above ceiling");

    a_ramp_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(ramp_duty_reg) && $stable(tick_count_reg))
        else $error("ramp moved without an input word");

endmodule

// ===== sim/bldc_hall_six_step_commutator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the hall six-step commutator: streams hall codes with
// bursty input and stalling output, predicts each word and compares it.
// Depends on bldc6s_pkg and bldc_hall_six_step_commutator_top.
module bldc_hall_six_step_commutator_top_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [bldc6s_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        bldc6s_pkg::duty_t duty_u;
        bldc6s_pkg::duty_t duty_v;
        bldc6s_pkg::duty_t duty_w;
        logic  low_u_on;
        logic  low_v_on;
        logic  low_w_on;
        logic  hall_fault;
    } phase_drive_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_BURSTY} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bldc6s_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bldc6s_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // commutation model: registers and ramp state
    logic dir_reg;
    bldc6s_pkg::duty_t min_reg, max_reg, step_reg;
    bldc6s_pkg::interval_t interval_reg;
    bldc6s_pkg::interval_t tick_cnt;
    bldc6s_pkg::duty_t ramp_level;
    logic ramp_up;

    logic [2:0] pending_q[$];
    phase_drive_t drive_q[$];
    int unsigned accepted_cnt = 0;
    int unsigned resolved_cnt = 0;
    bit failed = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int bursts_done = 0;
    bit draining = 1'b0;

    rx_mode_t rx_mode = RX_OPEN;
    int mode_left = 0;
    int stall_left = 0;
    int unsigned rx_cycle = 0;
    int idle_cycles = 0;

    bldc_hall_six_step_commutator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bldc6s_pkg::duty_t ceil_duty(input bldc6s_pkg::duty_t v);
        return (v > bldc6s_pkg::duty_t'(10000)) ? bldc6s_pkg::duty_t'(10000) : v;
    endfunction

    function automatic phase_drive_t commutate_tick(input logic [2:0] hall);
        logic [20:0] next_tick;
        logic [14:0] raised;
        bldc6s_pkg::duty_t lo, hi, st;
        logic [2:0] idx;
        bldc6s_pkg::phase_t high_side, low_side;
        phase_drive_t r;
        next_tick = {1'b0, tick_cnt} + 21'd1;
        if (next_tick >= {1'b0, interval_reg})
        begin
            tick_cnt = '0;
            lo = ceil_duty(min_reg);
            hi = ceil_duty(max_reg);
            st = ceil_duty(step_reg);
            if (ramp_up)
            begin
                raised = {1'b0, ramp_level} + {1'b0, st};
                if (raised >= {1'b0, hi})
                begin
                    ramp_level = hi;
                    ramp_up = 1'b0;
                end
                else
                    ramp_level = raised[13:0];
            end
            else if (ramp_level < st || ramp_level - st <= lo)
            begin
                ramp_level = lo;
                ramp_up = 1'b1;
            end
            else
                ramp_level = ramp_level - st;
        end
        else
            tick_cnt = next_tick[19:0];

        r = '0;
        if (hall == bldc6s_pkg::HALL_NONE_LO || hall == bldc6s_pkg::HALL_NONE_HI)
            r.hall_fault = 1'b1;
        else
        begin
            idx = dir_reg ? 3'd6 - hall : hall - 3'd1;
            case (idx)
                3'd0:
                begin
                    high_side = bldc6s_pkg::PHASE_U;
                    low_side = bldc6s_pkg::PHASE_W;
                end
                3'd1:
                begin
                    high_side = bldc6s_pkg::PHASE_V;
                    low_side = bldc6s_pkg::PHASE_U;
                end
                3'd2:
                begin
                    high_side = bldc6s_pkg::PHASE_V;
                    low_side = bldc6s_pkg::PHASE_W;
                end
                3'd3:
                begin
                    high_side = bldc6s_pkg::PHASE_W;
                    low_side = bldc6s_pkg::PHASE_V;
                end
                3'd4:
                begin
                    high_side = bldc6s_pkg::PHASE_U;
                    low_side = bldc6s_pkg::PHASE_V;
                end
                default:
                begin
                    high_side = bldc6s_pkg::PHASE_W;
                    low_side = bldc6s_pkg::PHASE_U;
                end
            endcase
            case (high_side)
                bldc6s_pkg::PHASE_U: r.duty_u = ramp_level;
                bldc6s_pkg::PHASE_V: r.duty_v = ramp_level;
                default:             r.duty_w = ramp_level;
            endcase
            case (low_side)
                bldc6s_pkg::PHASE_U: r.low_u_on = 1'b1;
                bldc6s_pkg::PHASE_V: r.low_v_on = 1'b1;
                default:             r.low_w_on = 1'b1;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [13:0] want,
                               input logic [13:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    // sender: bursts of words with random gaps, one drain pause every dozen bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                drive_q.push_back(commutate_tick(s_tdata[2:0]));
                void'(pending_q.pop_front());
                accepted_cnt <= accepted_cnt + 1;
            end
            if (draining && !s_tvalid && accepted_cnt == resolved_cnt)
                draining = 1'b0;
            if (draining || gap_left != 0 || pending_q.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, pending_q[0]};
                if (burst_left == 0)
                begin
                    bursts_done++;
                    if (bursts_done % 12 == 0)
                        draining = 1'b1;
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
                else
                    burst_left--;
            end
        end
    end

    // receiver: check each word, stall according to a randomly chosen mode that changes over time
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (resolved_cnt == accepted_cnt)
                begin
                    $error("m_tdata: word with no prediction pending");
                    failed = 1'b1;
                end
                else
                begin
                    phase_drive_t want;
                    want = drive_q.pop_front();
                    check_field("duty_u", want.duty_u, m_tdata[13:0]);
                    check_field("duty_v", want.duty_v, m_tdata[27:14]);
                    check_field("duty_w", want.duty_w, m_tdata[41:28]);
                    check_field("low_u_on", 14'(want.low_u_on), 14'(m_tdata[42]));
                    check_field("low_v_on", 14'(want.low_v_on), 14'(m_tdata[43]));
                    check_field("low_w_on", 14'(want.low_w_on), 14'(m_tdata[44]));
                    check_field("hall_fault", 14'(want.hall_fault), 14'(m_tuser[0]));
                    resolved_cnt <= resolved_cnt + 1;
                end
            end
            rx_cycle++;
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            else
                mode_left--;
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 99) < 70);
                RX_PATTERN: m_tready <= (rx_cycle % 5 != 2) && (rx_cycle % 7 != 4);
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end
                    else
                    begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(2, 16);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                idle_cycles++;
        end
    end

    task automatic write_reg(input logic [bldc6s_pkg::CFG_IDX_W-1:0] idx,
                             input logic [19:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bldc6s_pkg::REG_DIRECTION:     dir_reg = value[0];
            bldc6s_pkg::REG_DUTY_MIN:      min_reg = value[13:0];
            bldc6s_pkg::REG_DUTY_MAX:      max_reg = value[13:0];
            bldc6s_pkg::REG_DUTY_STEP:     step_reg = value[13:0];
            bldc6s_pkg::REG_RAMP_INTERVAL: interval_reg = value[19:0];
            default: ;
        endcase
    endtask

    task automatic hold_until_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || accepted_cnt != resolved_cnt);
    endtask

    function automatic logic [19:0] pick_duty_reg();
        case ($urandom_range(0, 9))
            0:       return 20'd0;
            1:       return 20'd10000;
            2:       return {6'($urandom), 14'h3FFF};
            3:       return 20'($urandom);
            default: return 20'($urandom_range(0, 10000));
        endcase
    endfunction

    function automatic logic [19:0] pick_step_reg();
        case ($urandom_range(0, 9))
            0:       return 20'd0;
            1:       return 20'd10000;
            2:       return 20'($urandom);
            default: return 20'($urandom_range(1, 1500));
        endcase
    endfunction

    function automatic logic [19:0] pick_interval_reg();
        case ($urandom_range(0, 9))
            0:       return 20'd0;
            1:       return 20'd1;
            2:       return 20'hFFFFF;
            3:       return 20'($urandom);
            default: return 20'($urandom_range(1, 6));
        endcase
    endfunction

    initial
    begin
        int n_items;
        logic [2:0] code;

        dir_reg = bldc6s_pkg::RST_DIRECTION;
        min_reg = bldc6s_pkg::RST_DUTY_MIN;
        max_reg = bldc6s_pkg::RST_DUTY_MAX;
        step_reg = bldc6s_pkg::RST_DUTY_STEP;
        interval_reg = bldc6s_pkg::RST_RAMP_INTERVAL;
        tick_cnt = '0;
        ramp_level = bldc6s_pkg::RST_RAMP_DUTY;
        ramp_up = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: every hall code, reversed order
        @(negedge clk);
        for (int c = 0; c < 8; c++)
            pending_q.push_back(3'(c));
        hold_until_idle();

        // narrow ramp stepping every tick, forward order, faults mid-ramp
        write_reg(bldc6s_pkg::REG_DIRECTION, 20'd0);
        write_reg(bldc6s_pkg::REG_DUTY_MIN, 20'd100);
        write_reg(bldc6s_pkg::REG_DUTY_MAX, 20'd400);
        write_reg(bldc6s_pkg::REG_DUTY_STEP, 20'd150);
        write_reg(bldc6s_pkg::REG_RAMP_INTERVAL, 20'd1);
        @(negedge clk);
        for (int c = 1; c <= 6; c++)
            pending_q.push_back(3'(c));
        pending_q.push_back(bldc6s_pkg::HALL_NONE_LO);
        pending_q.push_back(bldc6s_pkg::HALL_NONE_HI);
        hold_until_idle();

        // crossed bounds, oversized step, zero interval, dropped index
        write_reg(bldc6s_pkg::REG_DIRECTION, 20'd1);
        write_reg(bldc6s_pkg::REG_DUTY_MIN, 20'hFFFFF);
        write_reg(bldc6s_pkg::REG_DUTY_MAX, 20'd2000);
        write_reg(bldc6s_pkg::REG_DUTY_STEP, 20'd16383);
        write_reg(bldc6s_pkg::REG_RAMP_INTERVAL, 20'd0);
        write_reg(REG_SPARE, 20'hFFFFF);
        @(negedge clk);
        for (int c = 1; c <= 6; c++)
            pending_q.push_back(3'(c));
        hold_until_idle();

        // zero step holds the duty at the full-scale bound
        write_reg(bldc6s_pkg::REG_DUTY_MIN, 20'd0);
        write_reg(bldc6s_pkg::REG_DUTY_MAX, 20'd10000);
        write_reg(bldc6s_pkg::REG_DUTY_STEP, 20'd0);
        write_reg(bldc6s_pkg::REG_RAMP_INTERVAL, 20'd2);
        @(negedge clk);
        for (int c = 6; c >= 3; c--)
            pending_q.push_back(3'(c));
        hold_until_idle();

        for (int phase = 0; phase < 14; phase++)
        begin
            write_reg(bldc6s_pkg::REG_DIRECTION, 20'($urandom_range(0, 1)));
            write_reg(bldc6s_pkg::REG_DUTY_MIN, pick_duty_reg());
            write_reg(bldc6s_pkg::REG_DUTY_MAX, pick_duty_reg());
            write_reg(bldc6s_pkg::REG_DUTY_STEP, pick_step_reg());
            write_reg(bldc6s_pkg::REG_RAMP_INTERVAL, pick_interval_reg());
            n_items = $urandom_range(90, 140);
            @(negedge clk);
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                    code = $urandom_range(0, 1) ? bldc6s_pkg::HALL_NONE_HI
                                                : bldc6s_pkg::HALL_NONE_LO;
                else
                    code = 3'($urandom_range(1, 6));
                pending_q.push_back(code);
            end
            hold_until_idle();
        end

        repeat (4) @(posedge clk);
        if (failed || drive_q.size() != 0)
            $display("[FAIL] regression broken");
        else
            $display("[ OK ] regression clean");
        $finish;
    end

endmodule
